### rtl/core/srbt_pkg.sv
// Shared types, register indexes and saturating arithmetic helpers for the
// slide/roll ball trajectory pipeline. No dependencies.
package srbt_pkg;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [63:0] wide_t;

  localparam int CFG_IDX_W = 8;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BALL_RADIUS   = 8'd0;
  localparam cfg_idx_t CFG_ROLL_ACCEL    = 8'd1;
  localparam cfg_idx_t CFG_SLIDE_ACCEL   = 8'd2;
  localparam cfg_idx_t CFG_INERTIA_RATIO = 8'd3;

  localparam logic [16:0] RADIUS_RST  = 17'd1409;
  localparam q32_t        ROLL_RST    = -32'sd32768;
  localparam q32_t        SLIDE_RST   = -32'sd196608;
  localparam logic [30:0] INERTIA_RST = 31'd26214;

  localparam q32_t Q32_MAX = 32'sh7FFF_FFFF;
  localparam q32_t Q32_MIN = 32'sh8000_0000;

  // Clamp a wide signed value to 32 bits.
  function automatic q32_t sat32(wide_t x);
    if (x[63:31] == '0 || x[63:31] == '1) begin
      return x[31:0];
    end
    return x[63] ? Q32_MIN : Q32_MAX;
  endfunction

  // Product shifted right (floor) by sh, then saturated.
  function automatic q32_t mul_shr(q32_t a, q32_t b, int unsigned sh);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return sat32(p >>> sh);
  endfunction

endpackage

### rtl/core/slide_roll_ball_trajectory.sv
// Top level of the slide-then-roll ball trajectory query pipeline.
// Depends on srbt_pkg, srbt_sqrt and srbt_div.
//
// Usage:
//   Query channel: drive the in_ fields and raise start; busy is always low,
//   so a query transfers at every rising edge with start high, one per cycle.
//   Result channel: out_valid strobes for one cycle with out_pos_x/y and
//   out_vel_x/y; results leave in query order. The receiver cannot stall
//   and the pipeline never holds.
//   Configuration: cfg_valid/cfg_index/cfg_data, cfg_ready always high;
//   index 0 radius, 1 roll accel, 2 slide accel, 3 inertia; others dropped.
//   Write only while no query is in flight.
// Structure: two 32-stage square roots, three 34-stage dividers in series and
//   the multiply/saturate stages between them. Throughput: one query per
//   cycle.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
//   register reset values; no clearing pass.
module slide_roll_ball_trajectory #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [31:0]        in_start_x,
  input  logic signed [31:0]        in_start_y,
  input  logic signed [31:0]        in_kick_vx,
  input  logic signed [31:0]        in_kick_vy,
  input  logic signed [31:0]        in_spin_x,
  input  logic signed [31:0]        in_spin_y,
  input  logic [30:0]               in_query_time,
  output logic                      out_valid,
  output logic signed [31:0]        out_pos_x,
  output logic signed [31:0]        out_pos_y,
  output logic signed [31:0]        out_vel_x,
  output logic signed [31:0]        out_vel_y,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  srbt_pkg::cfg_idx_t        cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam srbt_pkg::wide_t ONE  = srbt_pkg::wide_t'(64'd1 << FRAC_BITS);
  localparam logic [31:0]     STILL_THR = 32'((64'd1 << FRAC_BITS) / 100);

  typedef srbt_pkg::q32_t q32_t;
  typedef srbt_pkg::wide_t wide_t;

  typedef struct packed {
    q32_t        px;
    q32_t        py;
    q32_t        vx;
    q32_t        vy;
    logic [30:0] t;
  } kin_t;

  typedef struct packed {
    kin_t kin;
    q32_t cx;
    q32_t cy;
  } sq1_side_t;

  typedef struct packed {
    kin_t kin;
    logic still;
  } dv1_side_t;

  typedef struct packed {
    kin_t kin;
    q32_t ax;
    q32_t ay;
    logic notime;
  } dv2_side_t;

  typedef struct packed {
    kin_t        kin;
    q32_t        ax;
    q32_t        ay;
    logic [30:0] ts;
    q32_t        vsx;
    q32_t        vsy;
    q32_t        psx;
    q32_t        psy;
  } sq2_side_t;

  typedef struct packed {
    sq2_side_t s;
    logic      nvs_zero;
    logic      roll_nonneg;
  } dv3_side_t;

  // configuration registers
  logic [16:0] radius_r;
  q32_t        roll_r;
  q32_t        slide_r;
  logic [30:0] inertia_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= srbt_pkg::RADIUS_RST;
      roll_r    <= srbt_pkg::ROLL_RST;
      slide_r   <= srbt_pkg::SLIDE_RST;
      inertia_r <= srbt_pkg::INERTIA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srbt_pkg::CFG_BALL_RADIUS:   radius_r  <= cfg_data[16:0];
        srbt_pkg::CFG_ROLL_ACCEL:    roll_r    <= cfg_data;
        srbt_pkg::CFG_SLIDE_ACCEL:   slide_r   <= cfg_data;
        srbt_pkg::CFG_INERTIA_RATIO: inertia_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // valid bits of the local stages
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic v11_r, v12_r, v13_r, v14_r, v15_r;
  logic sq1_v, dv1_v, dv2_v, sq2_v, dv3_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r} <= '0;
      {v8_r, v9_r, v10_r, v11_r, v12_r, v13_r, v14_r, v15_r} <= '0;
    end else begin
      v0_r  <= start && !busy;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= sq1_v;
      v6_r  <= dv1_v;
      v7_r  <= dv2_v;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= sq2_v;
      v12_r <= dv3_v;
      v13_r <= v12_r;
      v14_r <= v13_r;
      v15_r <= v14_r;
    end
  end

  // contact velocity and its squared norm
  kin_t  kin0_r, kin1_r, kin2_r, kin3_r;
  q32_t  wx0_r, wy0_r, mwx1_r, mwy1_r, cx2_r, cy2_r, cx3_r, cy3_r;
  wide_t sqx3_r, sqy3_r;
  sq1_side_t sq1_side_r;
  logic [63:0] sum4_r;
  q32_t  radius_q;

  assign radius_q = q32_t'({15'd0, radius_r});

  always_ff @(posedge clk) begin
    kin0_r <= '{px: in_start_x, py: in_start_y, vx: in_kick_vx, vy: in_kick_vy,
                t: in_query_time};
    wx0_r  <= in_spin_x;
    wy0_r  <= in_spin_y;

    kin1_r <= kin0_r;
    mwx1_r <= srbt_pkg::mul_shr(wx0_r, radius_q, FRAC_BITS);
    mwy1_r <= srbt_pkg::mul_shr(wy0_r, radius_q, FRAC_BITS);

    kin2_r <= kin1_r;
    cx2_r  <= srbt_pkg::sat32(wide_t'(kin1_r.vx) - wide_t'(mwx1_r));
    cy2_r  <= srbt_pkg::sat32(wide_t'(kin1_r.vy) - wide_t'(mwy1_r));

    kin3_r <= kin2_r;
    cx3_r  <= cx2_r;
    cy3_r  <= cy2_r;
    sqx3_r <= wide_t'(cx2_r) * wide_t'(cx2_r);
    sqy3_r <= wide_t'(cy2_r) * wide_t'(cy2_r);

    sq1_side_r <= '{kin: kin3_r, cx: cx3_r, cy: cy3_r};
    sum4_r     <= $unsigned(sqx3_r) + $unsigned(sqy3_r);
  end

  logic [31:0] nc;
  sq1_side_t   sq1_out;

  srbt_sqrt #(.SIDE_W($bits(sq1_side_t))) u_sqrt_contact (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v4_r),
    .in_rad   (sum4_r),
    .in_side  (sq1_side_r),
    .out_v    (sq1_v),
    .out_root (nc),
    .out_side (sq1_out)
  );

  // slide direction times acceleration and slip velocity
  logic [3:0][63:0] num5_r;
  logic [3:0][33:0] den5_r;
  dv1_side_t        dv1_side_r;
  wide_t            inertia_w;
  logic [32:0]      inertia_one;

  assign inertia_w   = wide_t'({33'd0, inertia_r});
  assign inertia_one = {2'b00, inertia_r} + 33'(ONE);

  always_ff @(posedge clk) begin
    num5_r[0]  <= wide_t'(sq1_out.cx) * wide_t'(slide_r);
    num5_r[1]  <= wide_t'(sq1_out.cy) * wide_t'(slide_r);
    num5_r[2]  <= -(wide_t'(sq1_out.cx) * inertia_w);
    num5_r[3]  <= -(wide_t'(sq1_out.cy) * inertia_w);
    den5_r[0]  <= {2'b00, nc};
    den5_r[1]  <= {2'b00, nc};
    den5_r[2]  <= {1'b0, inertia_one};
    den5_r[3]  <= {1'b0, inertia_one};
    dv1_side_r <= '{kin: sq1_out.kin, still: (nc < STILL_THR)};
  end

  logic [3:0][31:0] q1;
  dv1_side_t        dv1_out;

  srbt_div #(.LANES(4), .SIDE_W($bits(dv1_side_t))) u_div_slide (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v5_r),
    .in_num   (num5_r),
    .in_den   (den5_r),
    .in_side  (dv1_side_r),
    .out_v    (dv1_v),
    .out_quo  (q1),
    .out_side (dv1_out)
  );

  // pick the axis that sets the switch time
  q32_t        ax1, ay1, svx1, svy1;
  logic [31:0] abs_ax, abs_ay;
  logic [0:0][63:0] num6_r;
  logic [0:0][33:0] den6_r;
  dv2_side_t        dv2_side_r;
  logic             use_x, use_y;

  always_comb begin
    ax1    = dv1_out.still ? '0 : q32_t'(q1[0]);
    ay1    = dv1_out.still ? '0 : q32_t'(q1[1]);
    svx1   = q1[2];
    svy1   = q1[3];
    abs_ax = ax1[31] ? (~ax1 + 32'd1) : ax1;
    abs_ay = ay1[31] ? (~ay1 + 32'd1) : ay1;
    use_x  = (abs_ax != '0) && (abs_ax > abs_ay);
    use_y  = !use_x && (abs_ay != '0);
  end

  always_ff @(posedge clk) begin
    num6_r[0]  <= use_x ? (wide_t'(svx1) <<< FRAC_BITS) : (wide_t'(svy1) <<< FRAC_BITS);
    den6_r[0]  <= use_x ? 34'(ax1) : 34'(ay1);
    dv2_side_r <= '{kin: dv1_out.kin, ax: ax1, ay: ay1,
                    notime: dv1_out.still || !(use_x || use_y)};
  end

  logic [0:0][31:0] q2;
  dv2_side_t        dv2_out;

  srbt_div #(.LANES(1), .SIDE_W($bits(dv2_side_t))) u_div_switch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v6_r),
    .in_num   (num6_r),
    .in_den   (den6_r),
    .in_side  (dv2_side_r),
    .out_v    (dv2_v),
    .out_quo  (q2),
    .out_side (dv2_out)
  );

  // state at the switch from sliding to rolling
  kin_t        kin7_r, kin8_r, kin9_r;
  q32_t        ax7_r, ay7_r, ax8_r, ay8_r, ax9_r, ay9_r;
  logic [30:0] ts7_r, ts8_r, ts9_r;
  logic [30:0] ts_nxt;
  q32_t        matx7_r, maty7_r, mvx7_r, mvy7_r, mvx8_r, mvy8_r;
  q32_t        vsx8_r, vsy8_r, hx8_r, hy8_r, vsx9_r, vsy9_r, psx9_r, psy9_r;
  wide_t       sqx9_r, sqy9_r;
  sq2_side_t   sq2_side_r;
  logic [63:0] sum10_r;
  q32_t        ts_q7, ts_q8;

  // clamp negative switch times to zero; no switch time (notime) also gives zero
  assign ts_nxt = (dv2_out.notime || q2[0][31]) ? '0 : q2[0][30:0];
  assign ts_q7  = q32_t'({1'b0, ts_nxt});
  assign ts_q8  = q32_t'({1'b0, ts7_r});

  always_ff @(posedge clk) begin
    kin7_r  <= dv2_out.kin;
    ax7_r   <= dv2_out.ax;
    ay7_r   <= dv2_out.ay;
    ts7_r   <= ts_nxt;
    matx7_r <= srbt_pkg::mul_shr(dv2_out.ax, ts_q7, FRAC_BITS);
    maty7_r <= srbt_pkg::mul_shr(dv2_out.ay, ts_q7, FRAC_BITS);
    mvx7_r  <= srbt_pkg::mul_shr(dv2_out.kin.vx, ts_q7, FRAC_BITS);
    mvy7_r  <= srbt_pkg::mul_shr(dv2_out.kin.vy, ts_q7, FRAC_BITS);

    kin8_r  <= kin7_r;
    ax8_r   <= ax7_r;
    ay8_r   <= ay7_r;
    ts8_r   <= ts7_r;
    mvx8_r  <= mvx7_r;
    mvy8_r  <= mvy7_r;
    vsx8_r  <= srbt_pkg::sat32(wide_t'(kin7_r.vx) + wide_t'(matx7_r));
    vsy8_r  <= srbt_pkg::sat32(wide_t'(kin7_r.vy) + wide_t'(maty7_r));
    hx8_r   <= srbt_pkg::mul_shr(matx7_r, ts_q8, FRAC_BITS + 1);
    hy8_r   <= srbt_pkg::mul_shr(maty7_r, ts_q8, FRAC_BITS + 1);

    kin9_r  <= kin8_r;
    ax9_r   <= ax8_r;
    ay9_r   <= ay8_r;
    ts9_r   <= ts8_r;
    vsx9_r  <= vsx8_r;
    vsy9_r  <= vsy8_r;
    psx9_r  <= srbt_pkg::sat32(wide_t'(kin8_r.px) + wide_t'(mvx8_r) + wide_t'(hx8_r));
    psy9_r  <= srbt_pkg::sat32(wide_t'(kin8_r.py) + wide_t'(mvy8_r) + wide_t'(hy8_r));
    sqx9_r  <= wide_t'(vsx8_r) * wide_t'(vsx8_r);
    sqy9_r  <= wide_t'(vsy8_r) * wide_t'(vsy8_r);

    sq2_side_r <= '{kin: kin9_r, ax: ax9_r, ay: ay9_r, ts: ts9_r,
                    vsx: vsx9_r, vsy: vsy9_r, psx: psx9_r, psy: psy9_r};
    sum10_r    <= $unsigned(sqx9_r) + $unsigned(sqy9_r);
  end

  logic [31:0] nvs;
  sq2_side_t   sq2_out;

  srbt_sqrt #(.SIDE_W($bits(sq2_side_t))) u_sqrt_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v10_r),
    .in_rad   (sum10_r),
    .in_side  (sq2_side_r),
    .out_v    (sq2_v),
    .out_root (nvs),
    .out_side (sq2_out)
  );

  // rolling acceleration and time to rest
  logic [2:0][63:0] num11_r;
  logic [2:0][33:0] den11_r;
  dv3_side_t        dv3_side_r;

  always_ff @(posedge clk) begin
    num11_r[0] <= wide_t'(sq2_out.vsx) * wide_t'(roll_r);
    num11_r[1] <= wide_t'(sq2_out.vsy) * wide_t'(roll_r);
    num11_r[2] <= {32'd0, nvs} << FRAC_BITS;
    den11_r[0] <= {2'b00, nvs};
    den11_r[1] <= {2'b00, nvs};
    den11_r[2] <= -(34'(roll_r));
    dv3_side_r <= '{s: sq2_out, nvs_zero: (nvs == '0), roll_nonneg: !roll_r[31]};
  end

  logic [2:0][31:0] q3;
  dv3_side_t        dv3_out;

  srbt_div #(.LANES(3), .SIDE_W($bits(dv3_side_t))) u_div_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v11_r),
    .in_num   (num11_r),
    .in_den   (den11_r),
    .in_side  (dv3_side_r),
    .out_v    (dv3_v),
    .out_quo  (q3),
    .out_side (dv3_out)
  );

  // choose the phase the query time falls in
  q32_t        pos0x_nxt, pos0y_nxt, vel0x_nxt, vel0y_nxt, accx_nxt, accy_nxt;
  logic [30:0] tq_nxt;
  logic [30:0] tstop;
  logic [31:0] rest, tmin, t2;

  always_comb begin
    tstop = dv3_out.roll_nonneg ? 31'h7FFF_FFFF : q3[2][30:0];
    rest  = {1'b0, dv3_out.s.ts} + {1'b0, tstop};
    tmin  = ({1'b0, dv3_out.s.kin.t} > rest) ? rest : {1'b0, dv3_out.s.kin.t};
    t2    = tmin - {1'b0, dv3_out.s.ts};
    if (dv3_out.s.kin.t < dv3_out.s.ts) begin
      pos0x_nxt = dv3_out.s.kin.px;
      pos0y_nxt = dv3_out.s.kin.py;
      vel0x_nxt = dv3_out.s.kin.vx;
      vel0y_nxt = dv3_out.s.kin.vy;
      accx_nxt  = dv3_out.s.ax;
      accy_nxt  = dv3_out.s.ay;
      tq_nxt    = dv3_out.s.kin.t;
    end else begin
      pos0x_nxt = dv3_out.s.psx;
      pos0y_nxt = dv3_out.s.psy;
      vel0x_nxt = dv3_out.s.vsx;
      vel0y_nxt = dv3_out.s.vsy;
      accx_nxt  = dv3_out.nvs_zero ? '0 : q32_t'(q3[0]);
      accy_nxt  = dv3_out.nvs_zero ? '0 : q32_t'(q3[1]);
      tq_nxt    = t2[30:0];
    end
  end

  q32_t        pos0x12_r, pos0y12_r, vel0x12_r, vel0y12_r, accx12_r, accy12_r;
  logic [30:0] tq12_r, tq13_r;
  q32_t        pos0x13_r, pos0y13_r, vel0x13_r, vel0y13_r;
  q32_t        mvx13_r, mvy13_r, max13_r, may13_r;
  logic signed [33:0] pmx14_r, pmy14_r;
  q32_t        hx14_r, hy14_r, velx14_r, vely14_r;
  q32_t        posx15_r, posy15_r, velx15_r, vely15_r;
  q32_t        tq_q12, tq_q13;

  assign tq_q12 = q32_t'({1'b0, tq12_r});
  assign tq_q13 = q32_t'({1'b0, tq13_r});

  always_ff @(posedge clk) begin
    pos0x12_r <= pos0x_nxt;
    pos0y12_r <= pos0y_nxt;
    vel0x12_r <= vel0x_nxt;
    vel0y12_r <= vel0y_nxt;
    accx12_r  <= accx_nxt;
    accy12_r  <= accy_nxt;
    tq12_r    <= tq_nxt;

    pos0x13_r <= pos0x12_r;
    pos0y13_r <= pos0y12_r;
    vel0x13_r <= vel0x12_r;
    vel0y13_r <= vel0y12_r;
    tq13_r    <= tq12_r;
    mvx13_r   <= srbt_pkg::mul_shr(vel0x12_r, tq_q12, FRAC_BITS);
    mvy13_r   <= srbt_pkg::mul_shr(vel0y12_r, tq_q12, FRAC_BITS);
    max13_r   <= srbt_pkg::mul_shr(accx12_r, tq_q12, FRAC_BITS);
    may13_r   <= srbt_pkg::mul_shr(accy12_r, tq_q12, FRAC_BITS);

    pmx14_r   <= 34'(pos0x13_r) + 34'(mvx13_r);
    pmy14_r   <= 34'(pos0y13_r) + 34'(mvy13_r);
    hx14_r    <= srbt_pkg::mul_shr(max13_r, tq_q13, FRAC_BITS + 1);
    hy14_r    <= srbt_pkg::mul_shr(may13_r, tq_q13, FRAC_BITS + 1);
    velx14_r  <= srbt_pkg::sat32(wide_t'(vel0x13_r) + wide_t'(max13_r));
    vely14_r  <= srbt_pkg::sat32(wide_t'(vel0y13_r) + wide_t'(may13_r));

    posx15_r  <= srbt_pkg::sat32(wide_t'(pmx14_r) + wide_t'(hx14_r));
    posy15_r  <= srbt_pkg::sat32(wide_t'(pmy14_r) + wide_t'(hy14_r));
    velx15_r  <= velx14_r;
    vely15_r  <= vely14_r;
  end

  assign out_valid = v15_r;
  assign out_pos_x = posx15_r;
  assign out_pos_y = posy15_r;
  assign out_vel_x = velx15_r;
  assign out_vel_y = vely15_r;

endmodule

### rtl/core/srbt_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side
// payload carried alongside. Depends on nothing.
module srbt_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  logic [63:0]       in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_v,
  output logic [31:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = 32;

  logic [STEPS-1:0]  v_r;
  logic [63:0]       rem_r   [STEPS];
  logic [63:0]       res_r   [STEPS];
  logic [SIDE_W-1:0] side_r  [STEPS];
  logic [63:0]       rem_nxt [STEPS];
  logic [63:0]       res_nxt [STEPS];

  always_comb begin
    logic [63:0] src_rem;
    logic [63:0] src_res;
    logic [63:0] bit_k;
    logic [63:0] trial;
    for (int k = 0; k < STEPS; k++) begin
      src_rem = (k == 0) ? in_rad : rem_r[(k == 0) ? 0 : k-1];
      src_res = (k == 0) ? 64'd0  : res_r[(k == 0) ? 0 : k-1];
      bit_k   = 64'd1 << (62 - 2*k);
      trial   = src_res + bit_k;
      if (src_rem >= trial) begin
        rem_nxt[k] = src_rem - trial;
        res_nxt[k] = (src_res >> 1) + bit_k;
      end else begin
        rem_nxt[k] = src_rem;
        res_nxt[k] = src_res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[STEPS-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STEPS; k++) begin
      rem_r[k]  <= rem_nxt[k];
      res_r[k]  <= res_nxt[k];
      side_r[k] <= (k == 0) ? in_side : side_r[(k == 0) ? 0 : k-1];
    end
  end

  assign out_v    = v_r[STEPS-1];
  assign out_root = res_r[STEPS-1][31:0];
  assign out_side = side_r[STEPS-1];

endmodule

### rtl/core/srbt_div.sv
// Pipelined signed divider lanes (truncating, saturated to 32 bits), one
// quotient bit per stage, side payload carried along. Uses srbt_pkg.
module srbt_div #(
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_v,
  input  logic [LANES-1:0][63:0] in_num,
  input  logic [LANES-1:0][33:0] in_den,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_v,
  output logic [LANES-1:0][31:0] out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int STEPS = 32;

  logic [STEPS+1:0]  v_r;
  logic [63:0]       rem_r  [LANES][STEPS+1];
  logic [33:0]       den_r  [LANES][STEPS+1];
  logic [STEPS-1:0]  quo_r  [LANES][STEPS+1];
  logic              neg_r  [LANES][STEPS+1];
  logic              ovf_r  [LANES][STEPS+1];
  logic [SIDE_W-1:0] side_r [STEPS+1];
  logic [LANES-1:0][31:0] quo_out_r;
  logic [SIDE_W-1:0]      side_out_r;

  logic [63:0] mag_n  [LANES];
  logic [33:0] mag_d  [LANES];
  logic        neg_in [LANES];
  logic        ovf_in [LANES];
  logic        ok     [LANES][STEPS];
  logic [63:0] diff   [LANES][STEPS];
  srbt_pkg::q32_t quo_sat [LANES];

  always_comb begin
    logic [64:0] shifted;
    srbt_pkg::wide_t sq;
    for (int l = 0; l < LANES; l++) begin
      mag_n[l]  = in_num[l][63] ? (~in_num[l] + 64'd1) : in_num[l];
      mag_d[l]  = in_den[l][33] ? (~in_den[l] + 34'd1) : in_den[l];
      neg_in[l] = in_num[l][63] ^ in_den[l][33];
      // quotient does not fit 32 bits: saturate at the end
      ovf_in[l] = {2'b00, mag_n[l]} >= {mag_d[l], 32'd0};
      for (int k = 1; k <= STEPS; k++) begin
        shifted       = 65'(den_r[l][k-1]) << (STEPS - k);
        ok[l][k-1]    = {1'b0, rem_r[l][k-1]} >= shifted;
        diff[l][k-1]  = rem_r[l][k-1] - shifted[63:0];
      end
      sq = srbt_pkg::wide_t'({32'd0, quo_r[l][STEPS]});
      if (neg_r[l][STEPS]) begin
        sq = -sq;
      end
      if (ovf_r[l][STEPS]) begin
        quo_sat[l] = neg_r[l][STEPS] ? srbt_pkg::Q32_MIN : srbt_pkg::Q32_MAX;
      end else begin
        quo_sat[l] = srbt_pkg::sat32(sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[STEPS:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      rem_r[l][0] <= mag_n[l];
      den_r[l][0] <= mag_d[l];
      quo_r[l][0] <= '0;
      neg_r[l][0] <= neg_in[l];
      ovf_r[l][0] <= ovf_in[l];
      for (int k = 1; k <= STEPS; k++) begin
        rem_r[l][k] <= ok[l][k-1] ? diff[l][k-1] : rem_r[l][k-1];
        den_r[l][k] <= den_r[l][k-1];
        quo_r[l][k] <= {quo_r[l][k-1][STEPS-2:0], ok[l][k-1]};
        neg_r[l][k] <= neg_r[l][k-1];
        ovf_r[l][k] <= ovf_r[l][k-1];
      end
      quo_out_r[l] <= quo_sat[l];
    end
    side_r[0] <= in_side;
    for (int k = 1; k <= STEPS; k++) begin
      side_r[k] <= side_r[k-1];
    end
    side_out_r <= side_r[STEPS];
  end

  assign out_v    = v_r[STEPS+1];
  assign out_quo  = quo_out_r;
  assign out_side = side_out_r;

endmodule

### tb/slide_roll_ball_trajectory_tb.sv
// Self-checking testbench for the slide/roll ball trajectory query pipeline.
// Depends on srbt_pkg and the slide_roll_ball_trajectory RTL; no other files.
`timescale 1ns / 1ps

module slide_roll_ball_trajectory_tb;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 250;
  localparam srbt_pkg::cfg_idx_t CFG_UNUSED_IDX = 8'd9;

  typedef struct packed {
    logic signed [31:0] px, py, vx, vy, wx, wy;
    logic [30:0]        qt;
  } query_t;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  } state_t;

  typedef struct {
    query_t q;
    bit     typed;
    state_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  query_t drv_q = '0;
  logic drv_typed = 1'b0;
  state_t drv_res = '0;
  logic out_valid;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  srbt_pkg::cfg_idx_t cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Copy of the block's registers, tracked from observed writes
  longint m_radius, m_roll, m_slide, m_inertia;

  state_t pending_q[$];
  row_t   dir_rows[$];
  int     errors = 0;
  int     idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  slide_roll_ball_trajectory dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(drv_q.px), .in_start_y(drv_q.py),
    .in_kick_vx(drv_q.vx), .in_kick_vy(drv_q.vy),
    .in_spin_x(drv_q.wx), .in_spin_y(drv_q.wy),
    .in_query_time(drv_q.qt),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint clamp32(longint x);
    if (x > I32_MAX) return I32_MAX;
    if (x < I32_MIN) return I32_MIN;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b, int sh);
    longint p;
    p = a * b;
    return clamp32(p >>> sh);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint magnitude(longint x, longint y);
    longint unsigned s;
    s = longint'(x * x) + longint'(y * y);
    return longint'(int_sqrt(s));
  endfunction

  // Scale accel magnitude along the unit vector of (x, y); zero vector gives zero.
  function automatic void along(longint x, longint y, longint amag,
                                output longint ox, output longint oy);
    longint n;
    n = magnitude(x, y);
    if (n == 0) begin
      ox = 0;
      oy = 0;
    end else begin
      ox = clamp32((x * amag) / n);
      oy = clamp32((y * amag) / n);
    end
  endfunction

  function automatic state_t predict_trajectory(query_t q);
    longint px, py, vx, vy, wx, wy, t, cx, cy, ax, ay, ts, tt, svx, svy;
    longint vsx, vsy, psx, psy, arx, ary, tstop, rest, t2;
    state_t r;
    px = longint'(q.px); py = longint'(q.py);
    vx = longint'(q.vx); vy = longint'(q.vy);
    wx = longint'(q.wx); wy = longint'(q.wy);
    t = longint'({33'd0, q.qt});
    cx = clamp32(vx - qmul(wx, m_radius, FRAC));
    cy = clamp32(vy - qmul(wy, m_radius, FRAC));
    ax = 0; ay = 0; ts = 0;
    if (magnitude(cx, cy) >= ONE / 100) begin
      along(cx, cy, m_slide, ax, ay);
      svx = clamp32((-cx * m_inertia) / (m_inertia + ONE));
      svy = clamp32((-cy * m_inertia) / (m_inertia + ONE));
      tt = 0;
      // switch time from the axis that decelerates harder
      if (ax != 0 && (ax < 0 ? -ax : ax) > (ay < 0 ? -ay : ay)) tt = (svx * ONE) / ax;
      else if (ay != 0) tt = (svy * ONE) / ay;
      if (tt < 0) tt = 0;
      if (tt > I32_MAX) tt = I32_MAX;
      ts = tt;
    end
    vsx = clamp32(vx + qmul(ax, ts, FRAC));
    vsy = clamp32(vy + qmul(ay, ts, FRAC));
    psx = clamp32(px + qmul(vx, ts, FRAC) + qmul(qmul(ax, ts, FRAC), ts, FRAC + 1));
    psy = clamp32(py + qmul(vy, ts, FRAC) + qmul(qmul(ay, ts, FRAC), ts, FRAC + 1));
    along(vsx, vsy, m_roll, arx, ary);
    if (m_roll < 0) begin
      tstop = magnitude(vsx, vsy) * ONE / (-m_roll);
      if (tstop > I32_MAX) tstop = I32_MAX;
    end else begin
      tstop = I32_MAX;
    end
    rest = ts + tstop;
    if (t < ts) begin
      r.pos_x = clamp32(px + qmul(vx, t, FRAC) + qmul(qmul(ax, t, FRAC), t, FRAC + 1));
      r.pos_y = clamp32(py + qmul(vy, t, FRAC) + qmul(qmul(ay, t, FRAC), t, FRAC + 1));
      r.vel_x = clamp32(vx + qmul(ax, t, FRAC));
      r.vel_y = clamp32(vy + qmul(ay, t, FRAC));
    end else begin
      t2 = (t > rest ? rest : t) - ts;
      r.pos_x = clamp32(psx + qmul(vsx, t2, FRAC) + qmul(qmul(arx, t2, FRAC), t2, FRAC + 1));
      r.pos_y = clamp32(psy + qmul(vsy, t2, FRAC) + qmul(qmul(ary, t2, FRAC), t2, FRAC + 1));
      r.vel_x = clamp32(vsx + qmul(arx, t2, FRAC));
      r.vel_y = clamp32(vsy + qmul(ary, t2, FRAC));
    end
    return r;
  endfunction

  // Track config, queue predictions on query transfer, check results
  always @(posedge clk) begin
    state_t exp_r;
    if (!rst_n) begin
      m_radius  <= longint'({47'd0, srbt_pkg::RADIUS_RST});
      m_roll    <= longint'(srbt_pkg::ROLL_RST);
      m_slide   <= longint'(srbt_pkg::SLIDE_RST);
      m_inertia <= longint'({33'd0, srbt_pkg::INERTIA_RST});
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srbt_pkg::CFG_BALL_RADIUS:   m_radius  <= longint'({47'd0, cfg_data[16:0]});
          srbt_pkg::CFG_ROLL_ACCEL:    m_roll    <= longint'($signed(cfg_data));
          srbt_pkg::CFG_SLIDE_ACCEL:   m_slide   <= longint'($signed(cfg_data));
          srbt_pkg::CFG_INERTIA_RATIO: m_inertia <= longint'({33'd0, cfg_data[30:0]});
          default: ;
        endcase
      end
      if (start && !busy)
        pending_q.push_back(drv_typed ? drv_res : predict_trajectory(drv_q));
      if (out_valid) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result pos=(%0d,%0d) vel=(%0d,%0d)", $time,
                   out_pos_x, out_pos_y, out_vel_x, out_vel_y);
          errors++;
        end else begin
          exp_r = pending_q.pop_front();
          if (out_pos_x !== exp_r.pos_x || out_pos_y !== exp_r.pos_y ||
              out_vel_x !== exp_r.vel_x || out_vel_y !== exp_r.vel_y) begin
            $display("%0t: mismatch expected pos=(%0d,%0d) vel=(%0d,%0d)", $time,
                     exp_r.pos_x, exp_r.pos_y, exp_r.vel_x, exp_r.vel_y);
            $display("%0t:          actual   pos=(%0d,%0d) vel=(%0d,%0d)", $time,
                     out_pos_x, out_pos_y, out_vel_x, out_vel_y);
            errors++;
          end
        end
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("slide_roll_ball_trajectory_tb: errors");
        $finish;
      end
    end
  end

  task automatic add_row(logic signed [31:0] px, py, vx, vy, wx, wy, logic [30:0] qt,
                         bit typed, state_t res);
    row_t r;
    r.q = '{px, py, vx, vy, wx, wy, qt};
    r.typed = typed;
    r.res = res;
    dir_rows.push_back(r);
  endtask

  // Idle the sender for gap_pct of the cycles, then transfer one query
  task automatic send_query(query_t q, bit typed, state_t res, int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    drv_q <= q;
    drv_typed <= typed;
    drv_res <= res;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(srbt_pkg::cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] span(int unsigned mag);
    return $signed($urandom_range(0, 2 * mag)) - $signed(mag);
  endfunction

  function automatic query_t random_query();
    query_t q;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      // full-range noise
      q = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
    end else begin
      q.px = span(200 << FRAC);
      q.py = span(200 << FRAC);
      q.vx = span(12 << FRAC);
      q.vy = span(12 << FRAC);
      if (kind < 4) begin
        q.wx = 0;
        q.wy = 0;
      end else if (kind < 6 && m_radius != 0) begin
        // spin close to pure rolling
        q.wx = 32'((longint'(q.vx) * ONE) / m_radius) + span(3);
        q.wy = 32'((longint'(q.vy) * ONE) / m_radius) + span(3);
      end else begin
        q.wx = span(600 << FRAC);
        q.wy = span(600 << FRAC);
      end
      q.qt = (kind == 9) ? 31'($urandom) : 31'($urandom_range(0, 10 << FRAC));
    end
    return q;
  endfunction

  initial begin
    state_t none;
    int gap_pct;
    logic signed [31:0] pmax, pmin;
    none = '0;
    pmax = 32'sh7FFF_FFFF;
    pmin = 32'sh8000_0000;
    add_row(0, 0, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0});
    add_row(pmax, pmin, 0, 0, 0, 0, 31'h7FFF_FFFF, 1'b1, '{pmax, pmin, 0, 0});
    add_row(pmin, pmax, 0, 0, 0, 0, 31'h0000_1234, 1'b1, '{pmin, pmax, 0, 0});
    add_row(123456, -654321, 0, 0, 0, 0, 0, 1'b1, '{123456, -654321, 0, 0});
    add_row(0, 0, 3 << FRAC, 0, 0, 0, 0, 1'b1, '{0, 0, 3 << FRAC, 0});
    add_row(0, 0, 3 << FRAC, -2 << FRAC, 0, 0, 1 << FRAC, 1'b0, none);
    add_row(0, 0, 3 << FRAC, -2 << FRAC, 0, 0, 31'h7FFF_FFFF, 1'b0, none);
    add_row(5 << FRAC, 7 << FRAC, 4 << FRAC, 4 << FRAC, 100 << FRAC, -50 << FRAC,
            2 << FRAC, 1'b0, none);
    add_row(0, 0, 600, 0, 0, 0, 1 << FRAC, 1'b0, none);   // contact just under 0.01
    add_row(0, 0, 656, 0, 0, 0, 1 << FRAC, 1'b0, none);   // contact just over 0.01
    add_row(0, 0, 65536, 0, 3050 << FRAC, 0, 1 << FRAC, 1'b0, none); // spin far beyond pure roll
    add_row(pmax, pmax, pmax, pmax, 0, 0, 31'h7FFF_FFFF, 1'b0, none);
    add_row(pmin, pmin, pmin, pmin, pmax, pmin, 31'h7FFF_FFFF, 1'b0, none);
    add_row(pmax, pmin, pmin, pmax, pmin, pmax, 31'h4000_0000, 1'b0, none);
    add_row(0, 0, 0, 0, pmax, pmax, 3 << FRAC, 1'b0, none);
    add_row(-1, -1, -1, -1, -1, -1, 31'h2AAA_AAAA, 1'b0, none);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555, 1'b0, none);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_query(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].res, 30);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: gap_pct = 0;
        1: gap_pct = 45;
        2: gap_pct = 0;
        default: gap_pct = 37;
      endcase
      case (ph)
        1: begin
          write_reg(srbt_pkg::CFG_BALL_RADIUS, 32'd65536);
          write_reg(srbt_pkg::CFG_ROLL_ACCEL, 32'h8000_0000);
          write_reg(srbt_pkg::CFG_SLIDE_ACCEL, 32'h8000_0000);
          write_reg(srbt_pkg::CFG_INERTIA_RATIO, 32'h7FFF_FFFF);
          write_reg(CFG_UNUSED_IDX, 32'hDEAD_BEEF);
        end
        2: begin
          write_reg(srbt_pkg::CFG_BALL_RADIUS, 32'd1);
          write_reg(srbt_pkg::CFG_ROLL_ACCEL, 32'hFFFF_FFFF);
          write_reg(srbt_pkg::CFG_SLIDE_ACCEL, 32'd0);
          write_reg(srbt_pkg::CFG_INERTIA_RATIO, 32'd1);
        end
        3: begin
          write_reg(srbt_pkg::CFG_BALL_RADIUS, $urandom_range(1, 65536));
          write_reg(srbt_pkg::CFG_ROLL_ACCEL, -$urandom_range(1, 1 << 20));
          write_reg(srbt_pkg::CFG_SLIDE_ACCEL, -$urandom_range(0, 1 << 20));
          write_reg(srbt_pkg::CFG_INERTIA_RATIO, $urandom_range(1, 1 << 17));
        end
        default: ;
      endcase
      @(posedge clk);
      for (int n = 0; n < 100; n++) begin
        send_query(random_query(), 1'b0, none, gap_pct);
        // hold off once until the pipeline is empty
        if (ph == 1 && n == 50) drain();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("slide_roll_ball_trajectory_tb: clean");
    end else begin
      $display("slide_roll_ball_trajectory_tb: errors");
    end
    $finish;
  end

endmodule
